// File: rtl/tidf_pkg.sv
// Package for the trigger-id fragment filter: widths, codes, shared types.
// No dependencies; imported by every module of the block.
package tidf_pkg;

    localparam int CHANNEL_BITS  = 16;
    localparam int CHAN_DEPTH    = 1 << CHANNEL_BITS;
    localparam int WORD_BITS     = 32;
    localparam int TRIG_BITS     = 28;
    localparam int HDR_BITS      = 16;
    localparam int FMT_BITS      = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 28;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_BITS-1:0] CFG_HEADER_FORMAT     = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_THRESHOLD = 1'd1;

    localparam logic [FMT_BITS-1:0] FMT_CHAN14 = 2'd1;
    localparam logic [FMT_BITS-1:0] FMT_CHAN16 = 2'd2;

    localparam logic [3:0] KIND_HEADER  = 4'h8;
    localparam logic [3:0] KIND_TRIGGER = 4'h9;

    localparam logic [FMT_BITS-1:0]  RST_HEADER_FORMAT     = FMT_CHAN16;
    localparam logic [TRIG_BITS-1:0] RST_TRIGGER_THRESHOLD = 28'd100;

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [TRIG_BITS-1:0]    t_trig;

    typedef struct packed {
        t_chan chan;
        t_trig trig;
    } t_frag;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// File: rtl/tidf_if.sv
// Valid/ready channel interfaces for fragment words and keep decisions.
// Depends on tidf_pkg.
interface tidf_word_if;
    logic                           valid;
    logic                           ready;
    logic [tidf_pkg::WORD_BITS-1:0] data_word;
    logic                           last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface tidf_keep_if;
    logic valid;
    logic ready;
    logic keep_fragment;

    modport source (output valid, output keep_fragment, input ready);
    modport sink   (input valid, input keep_fragment, output ready);
endinterface

// File: rtl/tidf_front.sv
// Front end: accepts fragment words, tracks channel and trigger id, and
// queues one entry per fragment on its last word. Depends on tidf_pkg, tidf_if.
module tidf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tidf_word_if.sink                     i_in,
    input  logic [tidf_pkg::FMT_BITS-1:0] i_header_format,
    input  logic                          i_busy,
    input  tidf_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output tidf_pkg::t_frag               o_push_frag
);
    import tidf_pkg::*;

    t_chan                r_chan, n_chan;
    t_trig                r_trig, n_trig;
    logic [HDR_BITS-1:0]  hdr;
    logic                 accept;

    assign i_in.ready = !i_busy && !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        hdr    = HDR_BITS'(r_chan);
        n_trig = r_trig;
        case (i_in.data_word[31:28])
            KIND_HEADER: begin
                case (i_header_format)
                    FMT_CHAN14: hdr = {2'b00, i_in.data_word[17:4]};
                    FMT_CHAN16: hdr = i_in.data_word[19:4];
                    default:    hdr = HDR_BITS'(r_chan);
                endcase
            end
            KIND_TRIGGER: n_trig = i_in.data_word[TRIG_BITS-1:0];
            default: n_trig = r_trig;
        endcase
        n_chan = hdr[CHANNEL_BITS-1:0];
    end

    assign o_push           = accept && i_in.last_word;
    assign o_push_frag.chan = n_chan;
    assign o_push_frag.trig = n_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_trig <= '0;
        end else if (accept) begin
            if (i_in.last_word) begin
                r_chan <= '0;
                r_trig <= '0;
            end else begin
                r_chan <= n_chan;
                r_trig <= n_trig;
            end
        end
    end

endmodule

// File: rtl/tidf_queue.sv
// Short queue of per-fragment entries between front and back end.
// Depends on tidf_pkg.
module tidf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tidf_pkg::t_frag     i_push_frag,
    input  logic                i_pop,
    output tidf_pkg::t_frag     o_head,
    output tidf_pkg::t_q_status o_status
);
    import tidf_pkg::*;

    t_frag                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_PTR_BITS:0]   r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_frag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full && !i_pop |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PTR_BITS+1)'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// File: rtl/tidf_back.sv
// Back end: channel flag memory with clearing pass, keep/drop decision and
// output register. Depends on tidf_pkg, tidf_if.
module tidf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tidf_pkg::t_trig     i_threshold,
    input  tidf_pkg::t_frag     i_head,
    input  tidf_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_busy,
    tidf_keep_if.source         o_out
);
    import tidf_pkg::*;

    logic                  r_seen_mem [CHAN_DEPTH];
    logic [CHANNEL_BITS:0] r_clr_cnt;
    logic                  r_rd_seen;
    logic                  r_fwd_valid;
    t_chan                 r_fwd_chan;
    logic                  r_b_valid;
    t_frag                 r_b;
    logic                  r_out_valid;
    logic                  r_out_keep;

    logic                  clearing;
    logic                  b_fire;
    logic                  b_load;
    logic                  seen;
    logic                  keep;
    logic                  mark;

    assign clearing = !r_clr_cnt[CHANNEL_BITS];
    assign o_busy   = clearing;

    assign b_fire = r_b_valid && (!r_out_valid || o_out.ready);
    assign b_load = !clearing && !i_q_status.empty && (!r_b_valid || b_fire);
    assign o_pop  = b_load;

    always_comb begin
        seen = r_rd_seen || (r_fwd_valid && (r_fwd_chan == r_b.chan));
        keep = 1'b0;
        mark = 1'b0;
        if (r_b.trig != '0) begin
            if (seen) begin
                keep = 1'b1;
            end else if (r_b.trig < i_threshold) begin
                keep = 1'b1;
                mark = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_seen_mem[r_clr_cnt[CHANNEL_BITS-1:0]] <= 1'b0;
        end else if (b_fire && mark) begin
            r_seen_mem[r_b.chan] <= 1'b1;
        end
        if (b_load) begin
            r_rd_seen <= r_seen_mem[i_head.chan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b        <= i_head;
            r_fwd_chan <= r_b.chan;
        end
        if (b_fire) begin
            r_out_keep <= keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_fwd_valid <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (b_load) begin
                r_fwd_valid <= b_fire && mark;
            end
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.keep_fragment = r_out_keep;

`ifndef NO_ASSERTIONS
    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !r_b_valid && !r_out_valid && !o_pop)
        else $error("fragment in flight during clearing pass");
    a_zero_trigger_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire && (r_b.trig == '0) |=> r_out_valid && !r_out_keep)
        else $error("zero trigger id kept");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_keep))
        else $error("stalled decision changed");
`endif

endmodule

// File: rtl/trigger_id_fragment_filter_top.sv
// Top level of the trigger-id fragment filter: configuration registers and
// front, queue and back end. Depends on tidf_pkg, tidf_if and all tidf_ modules.
//
//   channel   dir  transaction               payload
//   i_in      in   one fragment word         data_word[31:0], last_word
//   o_out     out  one decision per fragment keep_fragment
//   cfg       in   register write            i_cfg_idx, i_cfg_data[27:0]
//
// One word is accepted per cycle while i_in.ready is high; a fragment's entry
// passes the queue and the back end's fragment register before o_out.valid rises.
// After reset a clearing pass zeroes every entry of the channel flag memory;
// i_in.ready stays low until it ends. Configuration writes are taken at any time.
// An output stall fills the back end and then the four-entry queue before
// i_in.ready drops.
module trigger_id_fragment_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tidf_word_if.sink                          i_in,
    tidf_keep_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [tidf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tidf_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import tidf_pkg::*;

    logic [FMT_BITS-1:0] r_header_format;
    t_trig               r_threshold;
    logic                push;
    t_frag               push_frag;
    logic                pop;
    t_frag               head;
    t_q_status           q_status;
    logic                busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_format <= RST_HEADER_FORMAT;
            r_threshold     <= RST_TRIGGER_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_FORMAT:     r_header_format <= i_cfg_data[FMT_BITS-1:0];
                CFG_TRIGGER_THRESHOLD: r_threshold     <= i_cfg_data[TRIG_BITS-1:0];
                default:               r_threshold     <= r_threshold;
            endcase
        end
    end

    tidf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_header_format (r_header_format),
        .i_busy          (busy),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_push_frag     (push_frag)
    );

    tidf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_frag (push_frag),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    tidf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_out       (o_out)
    );

endmodule
